// ----- sv/bvtp_pkg.sv -----
// Package: shared constants, types and helpers for the best-view projection core.
`timescale 1ns / 1ps
package bvtp_pkg;
    localparam int MAX_CAMERAS_DEF = 64;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int WORDS_PER_CAM   = 12;
    localparam int WORD_W          = 32;
    localparam int ADDR_W          = 10;
    localparam int CNT_W           = 7;
    localparam int IDX_W           = 6;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_FACE = 1'b1;

    typedef logic signed [WORD_W-1:0] t_word;

    function automatic t_word sat32(input logic signed [65:0] v);
        t_word r;
        if (v > 66'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction
endpackage

// ----- sv/best_view_texture_projection_core.sv -----
// Top level of the best-view texture projection core.
// Load items are taken one per cycle, back to back, while no face item or result is pending.
// A face item runs through edge, normal, camera scan, projection and divide states, using
// the shared multiplier and the serial divider; a zero depth skips its two quotients.
// One item at a time; input stalls until the result is taken.
// Reset (synchronous, active low) clears control and sets count to 1; table not cleared.
`timescale 1ns / 1ps
module best_view_texture_projection_core #(
    parameter int MAX_CAMERAS = bvtp_pkg::MAX_CAMERAS_DEF,
    parameter int FRAC_BITS   = bvtp_pkg::FRAC_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_req_type,
    input  logic [bvtp_pkg::ADDR_W-1:0] i_param_addr,
    input  logic signed [31:0]       i_param_value,
    input  logic signed [31:0]       i_vert1_x,
    input  logic signed [31:0]       i_vert1_y,
    input  logic signed [31:0]       i_vert1_z,
    input  logic signed [31:0]       i_vert2_x,
    input  logic signed [31:0]       i_vert2_y,
    input  logic signed [31:0]       i_vert2_z,
    input  logic signed [31:0]       i_vert3_x,
    input  logic signed [31:0]       i_vert3_y,
    input  logic signed [31:0]       i_vert3_z,
    input  logic                     i_cfg_we,
    input  logic [6:0]               i_cfg_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [5:0]               o_image_index,
    output logic signed [31:0]       o_tex1_u,
    output logic signed [31:0]       o_tex1_v,
    output logic signed [31:0]       o_tex2_u,
    output logic signed [31:0]       o_tex2_v,
    output logic signed [31:0]       o_tex3_u,
    output logic signed [31:0]       o_tex3_v,
    output logic                     o_divide_error
);
    import bvtp_pkg::*;
    localparam int DEPTH = MAX_CAMERAS * WORDS_PER_CAM;
    localparam int TA_W  = $clog2(DEPTH);
    localparam int CI_W  = $clog2(MAX_CAMERAS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_EDGE, S_NRM, S_SCAN, S_PROJ, S_DIV, S_OUT
    } t_state;

    t_state r_state;
    t_word  r_mem [DEPTH];
    t_word  r_rd;
    logic [TA_W-1:0] r_ra;
    logic [CNT_W-1:0] r_count;
    t_word  r_v [9];
    t_word  r_e [6];
    t_word  r_n [3];
    t_word  r_c [3];
    t_word  r_tex [6];
    logic   r_derr;
    logic [CI_W-1:0] r_cam, r_best, r_lim;
    logic signed [65:0] r_acc, r_bestd;
    logic [4:0] r_step;
    logic [1:0] r_vi;
    logic       r_dv;
    logic       r_first;
    logic       r_ovalid;

    t_word m_a, m_b;
    logic signed [47:0] m_p;
    logic d_start, d_done;
    t_word d_num, d_quo;

    bvtp_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
        .i_clk(i_clk), .i_a(m_a), .i_b(m_b), .o_p(m_p)
    );
    bvtp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(d_start), .i_num(d_num),
        .i_den(r_c[2]), .o_done(d_done), .o_quo(d_quo)
    );

    assign o_stall = (r_state != S_IDLE) || r_ovalid;
    assign o_valid = r_ovalid;
    wire acc_in = i_valid && !o_stall;

    // Step plan per phase; the table address is registered in r_ra and its data in r_rd.
    // SCAN per camera: steps 0..2 read words 6..8, mul, accumulate, step 6 compare.
    // PROJ per vertex: each rotation row's three words, then that row's translation.
    logic [3:0] n_word;
    always_comb begin
        n_word = 4'd0;
        if (r_state == S_SCAN) n_word = 4'(6 + ((r_step > 5'd2) ? 2 : r_step));
        else if (r_state == S_PROJ) begin
            if (r_step[1:0] == 2'd3) n_word = 4'd9 + 4'(r_step[3:2]);
            else n_word = 4'(r_step[3:2]) * 4'd3 + 4'(r_step[1:0]);
        end
    end
    wire [TA_W+4:0] n_ra_w = (TA_W+5)'((r_state == S_SCAN ? r_cam : r_best))
                             * (TA_W+5)'(WORDS_PER_CAM) + (TA_W+5)'(n_word);

    // vertex component for the rotation word held in r_rd
    logic [1:0] n_vj;
    logic [3:0] n_vx;
    always_comb begin
        case (r_step[1:0])
            2'd2: n_vj = 2'd0;
            2'd3: n_vj = 2'd1;
            default: n_vj = 2'd2;
        endcase
        n_vx = 4'(r_vi) * 4'd3 + 4'(n_vj);
    end

    always_comb begin
        m_a = r_e[1]; m_b = r_e[5];
        case (r_state)
            S_NRM: begin
                case (r_step)
                    5'd0: begin m_a = r_e[1]; m_b = r_e[5]; end
                    5'd1: begin m_a = r_e[2]; m_b = r_e[4]; end
                    5'd2: begin m_a = r_e[2]; m_b = r_e[3]; end
                    5'd3: begin m_a = r_e[0]; m_b = r_e[5]; end
                    5'd4: begin m_a = r_e[0]; m_b = r_e[4]; end
                    default: begin m_a = r_e[1]; m_b = r_e[3]; end
                endcase
            end
            S_SCAN: begin
                m_a = r_rd;
                case (r_step)
                    5'd3: m_b = r_n[1];
                    5'd4: m_b = r_n[2];
                    default: m_b = r_n[0];
                endcase
            end
            S_PROJ: begin
                m_a = r_rd;
                m_b = r_v[n_vx];
            end
            default: ;
        endcase
    end

    assign d_start = (r_state == S_DIV) && r_step == 5'd0;
    assign d_num   = r_dv ? r_c[1] : r_c[0];

    always_ff @(posedge i_clk) begin
        if (acc_in && i_req_type == REQ_LOAD && 32'(i_param_addr) < DEPTH) begin
            r_mem[TA_W'(i_param_addr)] <= i_param_value;
        end
        r_rd <= r_mem[r_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= 7'd1;
            r_ovalid <= 1'b0;
            r_step   <= '0;
        end else begin
            if (i_cfg_we) r_count <= i_cfg_data;
            if (r_ovalid && !i_stall) r_ovalid <= 1'b0;
            r_ra <= TA_W'(n_ra_w);
            case (r_state)
                S_IDLE: begin
                    if (acc_in && i_req_type == REQ_FACE) begin
                        r_v[0] <= i_vert1_x; r_v[1] <= i_vert1_y; r_v[2] <= i_vert1_z;
                        r_v[3] <= i_vert2_x; r_v[4] <= i_vert2_y; r_v[5] <= i_vert2_z;
                        r_v[6] <= i_vert3_x; r_v[7] <= i_vert3_y; r_v[8] <= i_vert3_z;
                        r_state <= S_EDGE;
                    end
                end
                S_EDGE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_e[k]   <= sat32(66'(r_v[3+k]) - 66'(r_v[k]));
                        r_e[3+k] <= sat32(66'(r_v[6+k]) - 66'(r_v[k]));
                    end
                    r_step  <= '0;
                    r_state <= S_NRM;
                    if (r_count == 7'd0) r_lim <= CI_W'(1);
                    else if (32'(r_count) > MAX_CAMERAS) r_lim <= CI_W'(MAX_CAMERAS);
                    else r_lim <= CI_W'(r_count);
                end
                S_NRM: begin
                    // products are read from the multiplier's output register
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        5'd1, 5'd3, 5'd5: r_acc <= 66'(m_p);
                        5'd2: r_n[0] <= sat32(r_acc - 66'(m_p));
                        5'd4: r_n[1] <= sat32(r_acc - 66'(m_p));
                        5'd6: begin
                            r_n[2]  <= sat32(r_acc - 66'(m_p));
                            r_cam   <= '0;
                            r_first <= 1'b1;
                            r_step  <= '0;
                            r_state <= S_SCAN;
                        end
                        default: ;
                    endcase
                end
                S_SCAN: begin
                    // addr issued step0, data step2 (rd valid), mul reg step3
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        5'd3: r_acc <= 66'(m_p);
                        5'd4, 5'd5: r_acc <= r_acc + 66'(m_p);
                        5'd6: begin
                            if (r_first || r_acc > r_bestd) begin
                                r_bestd <= r_acc;
                                r_best  <= r_cam;
                            end
                            r_first <= 1'b0;
                            r_step  <= '0;
                            if (r_cam + 1'b1 == r_lim) begin
                                r_state <= S_PROJ;
                                r_vi    <= '0;
                                r_derr  <= 1'b0;
                            end
                            r_cam <= r_cam + 1'b1;
                        end
                        default: ;
                    endcase
                end
                S_PROJ: begin
                    // row k: products land at steps 4k+3..4k+5, translation in r_rd at 4k+5
                    r_step <= r_step + 1'b1;
                    case (r_step)
                        5'd3, 5'd7, 5'd11: r_acc <= 66'(m_p);
                        5'd4, 5'd8, 5'd12: r_acc <= r_acc + 66'(m_p);
                        5'd5: r_c[0] <= sat32(r_acc + 66'(m_p) + 66'(r_rd));
                        5'd9: r_c[1] <= sat32(r_acc + 66'(m_p) + 66'(r_rd));
                        5'd13: begin
                            r_c[2]  <= sat32(r_acc + 66'(m_p) + 66'(r_rd));
                            r_step  <= '0;
                            r_dv    <= 1'b0;
                            r_state <= S_DIV;
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (r_c[2] == '0) begin
                        r_derr <= 1'b1;
                        r_tex[{r_vi, 1'b0}] <= '0;
                        r_tex[{r_vi, 1'b1}] <= '0;
                        r_step <= 5'd2;
                        r_dv   <= 1'b1;
                    end else if (r_step == 5'd0) begin
                        r_step <= 5'd1;
                    end else if (d_done) begin
                        r_tex[{r_vi, r_dv}] <= d_quo;
                        r_step <= r_dv ? 5'd2 : 5'd0;
                        r_dv   <= 1'b1;
                    end
                    if (r_step == 5'd2) begin
                        r_step <= '0;
                        if (r_vi == 2'd2) r_state <= S_OUT;
                        else begin
                            r_vi    <= r_vi + 1'b1;
                            r_state <= S_PROJ;
                        end
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_image_index  = IDX_W'(r_best);
    assign o_tex1_u       = r_tex[0];
    assign o_tex1_v       = r_tex[1];
    assign o_tex2_u       = r_tex[2];
    assign o_tex2_v       = r_tex[3];
    assign o_tex3_u       = r_tex[4];
    assign o_tex3_v       = r_tex[5];
    assign o_divide_error = r_derr;
endmodule

// ----- sv/bvtp_div.sv -----
// Serial restoring divider: (num << FRAC) / den, truncated toward zero, saturated.
`timescale 1ns / 1ps
module bvtp_div #(
    parameter int FRAC_BITS = bvtp_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  bvtp_pkg::t_word     i_num,
    input  bvtp_pkg::t_word     i_den,
    output logic                o_done,
    output bvtp_pkg::t_word     o_quo
);
    import bvtp_pkg::*;
    localparam int NW = 32 + FRAC_BITS;
    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] r_q;
    logic [32:0]   r_rem;
    logic [31:0]   r_d;
    logic          r_neg;
    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [33:0]   n_rem;
    logic [33:0]   n_sub;
    logic [NW-1:0] n_a;
    logic signed [NW+1:0] n_sq;

    assign n_rem = {r_rem, r_q[NW-1]};
    assign n_sub = n_rem - {2'b0, r_d};
    assign n_sq  = r_neg ? -$signed({2'b0, r_q}) : $signed({2'b0, r_q});
    assign n_a   = i_num[31] ? NW'(-{{(NW-32){i_num[31]}}, i_num} <<< 0) : NW'(i_num);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= n_a << FRAC_BITS;
                r_rem  <= '0;
                r_d    <= i_den[31] ? 32'(-i_den) : 32'(i_den);
                r_neg  <= i_num[31] ^ i_den[31];
            end else if (r_busy) begin
                if (!n_sub[33]) begin
                    r_rem <= n_sub[32:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem[32:0];
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    assign o_quo = sat32(66'(n_sq));
endmodule

// ----- sv/bvtp_mac.sv -----
// Shared multiply unit: registered Q product, floor-shifted.
`timescale 1ns / 1ps
module bvtp_mac #(
    parameter int FRAC_BITS = bvtp_pkg::FRAC_BITS_DEF
) (
    input  logic                    i_clk,
    input  bvtp_pkg::t_word         i_a,
    input  bvtp_pkg::t_word         i_b,
    output logic signed [47:0]      o_p
);
    import bvtp_pkg::*;
    logic signed [63:0] r_prod;
    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end
    assign o_p = 48'(r_prod >>> FRAC_BITS);
endmodule

// ----- dv/tb_best_view_texture_projection_core.sv -----
// Self-checking testbench for the best-view texture projection core.
`timescale 1ns / 1ps
module tb_best_view_texture_projection_core;
    import bvtp_pkg::*;

    localparam int NCAM  = MAX_CAMERAS_DEF;
    localparam int DEPTH = NCAM * WORDS_PER_CAM;
    localparam int FB    = FRAC_BITS_DEF;

    typedef struct packed {
        logic [5:0]   idx;
        logic [31:0]  u1, v1, u2, v2, u3, v3;
        logic         derr;
    } t_tex;

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, i_req_type;
    logic [9:0] i_param_addr;
    logic signed [31:0] i_param_value;
    logic signed [31:0] i_vert1_x, i_vert1_y, i_vert1_z;
    logic signed [31:0] i_vert2_x, i_vert2_y, i_vert2_z;
    logic signed [31:0] i_vert3_x, i_vert3_y, i_vert3_z;
    logic i_cfg_we;
    logic [6:0] i_cfg_data;
    logic o_valid, i_stall;
    logic [5:0] o_image_index;
    logic signed [31:0] o_tex1_u, o_tex1_v, o_tex2_u, o_tex2_v, o_tex3_u, o_tex3_v;
    logic o_divide_error;

    best_view_texture_projection_core dut (.*);

    logic signed [31:0] cam_tbl [DEPTH];
    logic [6:0] cam_cnt;
    t_tex tex_q[$];
    int errors;
    int mism;
    bit stall_mode;

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #50000000;
        $display("FAILURE");
        $finish;
    end

    function automatic logic signed [63:0] fl_shift(input logic signed [63:0] v);
        return v >>> FB;
    endfunction

    function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
        return fl_shift(a * b);
    endfunction

    function automatic logic signed [63:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [31:0] qdiv(input logic signed [63:0] n,
                                        input logic signed [63:0] d);
        logic signed [63:0] q;
        q = (n * 64'sd65536) / d;
        return 32'(clamp32(q));
    endfunction

    function automatic t_tex project_face(input logic signed [31:0] vt [9]);
        logic signed [63:0] v [3][3];
        logic signed [63:0] e1 [3], e2 [3], nrm [3], c [3];
        logic signed [63:0] best, d;
        int bi, cnt;
        t_tex r;
        for (int i = 0; i < 3; i++)
            for (int k = 0; k < 3; k++) v[i][k] = vt[i*3+k];
        for (int k = 0; k < 3; k++) begin
            e1[k] = clamp32(v[1][k] - v[0][k]);
            e2[k] = clamp32(v[2][k] - v[0][k]);
        end
        nrm[0] = clamp32(qmul(e1[1], e2[2]) - qmul(e1[2], e2[1]));
        nrm[1] = clamp32(qmul(e1[2], e2[0]) - qmul(e1[0], e2[2]));
        nrm[2] = clamp32(qmul(e1[0], e2[1]) - qmul(e1[1], e2[0]));
        cnt = cam_cnt;
        if (cnt == 0) cnt = 1;
        if (cnt > NCAM) cnt = NCAM;
        best = 0;
        bi = 0;
        for (int j = 0; j < cnt; j++) begin
            d = qmul(cam_tbl[j*12+6], nrm[0]) + qmul(cam_tbl[j*12+7], nrm[1])
              + qmul(cam_tbl[j*12+8], nrm[2]);
            if (j == 0 || d > best) begin
                best = d;
                bi = j;
            end
        end
        r = '0;
        r.idx = bi[5:0];
        for (int i = 0; i < 3; i++) begin
            logic [31:0] uu, vv;
            for (int k = 0; k < 3; k++)
                c[k] = clamp32(qmul(cam_tbl[bi*12+k*3], v[i][0])
                             + qmul(cam_tbl[bi*12+k*3+1], v[i][1])
                             + qmul(cam_tbl[bi*12+k*3+2], v[i][2])
                             + cam_tbl[bi*12+9+k]);
            if (c[2] == 0) begin
                r.derr = 1;
                uu = 0;
                vv = 0;
            end else begin
                uu = qdiv(c[0], c[2]);
                vv = qdiv(c[1], c[2]);
            end
            case (i)
                0: begin r.u1 = uu; r.v1 = vv; end
                1: begin r.u2 = uu; r.v2 = vv; end
                default: begin r.u3 = uu; r.v3 = vv; end
            endcase
        end
        return r;
    endfunction

    // sender: bursts with random gaps
    int burst_left;

    task automatic send_item(input logic rt, input logic [9:0] addr,
                             input logic signed [31:0] val,
                             input logic signed [31:0] vt [9]);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? int'($urandom_range(1, 30)) : 0;
            if (gap > 0) begin
                i_valid <= 0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        i_valid       <= 1;
        i_req_type    <= rt;
        i_param_addr  <= addr;
        i_param_value <= val;
        i_vert1_x <= vt[0]; i_vert1_y <= vt[1]; i_vert1_z <= vt[2];
        i_vert2_x <= vt[3]; i_vert2_y <= vt[4]; i_vert2_z <= vt[5];
        i_vert3_x <= vt[6]; i_vert3_y <= vt[7]; i_vert3_z <= vt[8];
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        if (rt == REQ_LOAD) begin
            if (addr < DEPTH) cam_tbl[addr] = val;
        end else begin
            tex_q = {tex_q, project_face(vt)};
        end
    endtask

    task automatic load_word(input int addr, input logic signed [31:0] val);
        logic signed [31:0] vt [9];
        foreach (vt[i]) vt[i] = $urandom;
        send_item(REQ_LOAD, addr[9:0], val, vt);
    endtask

    task automatic face(input logic signed [31:0] vt [9]);
        send_item(REQ_FACE, 10'($urandom), $urandom, vt);
    endtask

    function automatic logic signed [31:0] small_val();
        return $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    endfunction

    task automatic rand_face(input bit wide);
        logic signed [31:0] vt [9];
        foreach (vt[i]) vt[i] = wide ? $signed($urandom) : small_val();
        face(vt);
    endtask

    task automatic wait_idle();
        int guard;
        guard = 0;
        i_valid <= 0;
        while (tex_q.size() != 0 && guard < 2000000) begin
            @(posedge i_clk);
            guard++;
        end
        if (tex_q.size() != 0) begin
            $display("FAILURE");
            $finish;
        end
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_count(input logic [6:0] n);
        wait_idle();
        i_cfg_we   <= 1;
        i_cfg_data <= n;
        @(posedge i_clk);
        i_cfg_we <= 0;
        cam_cnt = n;
    endtask

    task automatic load_cameras(input int n, input bit wide);
        for (int j = 0; j < n; j++)
            for (int w = 0; w < WORDS_PER_CAM; w++)
                load_word(j * 12 + w, wide ? $signed($urandom) : small_val());
    endtask

    task automatic test_directed();
        logic signed [31:0] vt [9];
        load_cameras(NCAM, 0);
        foreach (vt[i]) vt[i] = 0;
        face(vt);                                   // degenerate face
        foreach (vt[i]) vt[i] = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
        face(vt);
        foreach (vt[i]) vt[i] = 32'sh7fffffff;
        face(vt);
        vt = '{0, 0, 0, 1 << 16, 0, 0, 0, 1 << 16, 0};
        face(vt);
        load_word(767, 32'sh80000000);
        load_word(768, 32'sh7fffffff);              // beyond table, ignored
        load_word(1023, 0);
        // zero depth on camera 0
        for (int w = 0; w < 12; w++) load_word(w, 0);
        face(vt);
        load_word(8, 1 << 16);
        load_word(11, 1 << 16);
        face(vt);
    endtask

    task automatic test_counts();
        logic [6:0] cnts [6] = '{0, 1, 64, 127, 65, 7'd33};
        foreach (cnts[c]) begin
            set_count(cnts[c]);
            for (int i = 0; i < 8; i++) rand_face($urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_random();
        for (int i = 0; i < 260; i++) begin
            if (i % 50 == 0) set_count(7'($urandom_range(0, 127)));
            case ($urandom_range(0, 9))
                0: load_word($urandom_range(0, 1023), $signed($urandom));
                1: load_word($urandom_range(0, DEPTH - 1), small_val());
                2: rand_face(1);
                default: rand_face(0);
            endcase
        end
    endtask

    // receiver stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall    <= 0;
            stall_mode <= 0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
            i_stall <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            t_tex got, exp;
            got = '{o_image_index, o_tex1_u, o_tex1_v, o_tex2_u, o_tex2_v,
                    o_tex3_u, o_tex3_v, o_divide_error};
            if (tex_q.size() == 0) begin
                errors++;
                if (mism++ < 10) $display("unexpected result %h", got);
            end else begin
                exp = tex_q.pop_front();
                if (got !== exp) begin
                    errors++;
                    if (mism++ < 10)
                        $display("mismatch: idx %0d/%0d u1 %h/%h v1 %h/%h",
                                 exp.idx, got.idx, exp.u1, got.u1, exp.v1, got.v1,
                                 " u2 %h/%h v2 %h/%h u3 %h/%h v3 %h/%h err %b/%b",
                                 exp.u2, got.u2, exp.v2, got.v2, exp.u3, got.u3,
                                 exp.v3, got.v3, exp.derr, got.derr);
                end
            end
        end
    end

    initial begin
        errors = 0; mism = 0; burst_left = 0;
        i_rst_n = 0; i_valid = 0; i_req_type = 0; i_param_addr = 0; i_param_value = 0;
        {i_vert1_x, i_vert1_y, i_vert1_z, i_vert2_x, i_vert2_y, i_vert2_z,
         i_vert3_x, i_vert3_y, i_vert3_z} = '0;
        i_cfg_we = 0; i_cfg_data = 0;
        cam_cnt = 1;
        foreach (cam_tbl[i]) cam_tbl[i] = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        set_count(64);
        test_directed();
        test_counts();
        test_random();
        wait_idle();
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
